[src/vn_pkg.sv]
// shared constants for the vector normalisation pipeline
`timescale 1ns / 1ps
package vn_pkg;
   localparam int CW         = 32;
   localparam int ROOT_W     = CW;
   localparam int SUM_W      = 2 * CW;
   localparam int MAG_W      = CW + 1;
   localparam int SQ_REM_W   = ROOT_W + 3;
   localparam int UNIT_W     = 32;
   localparam int UNIT_FRAC  = 30;
   localparam int DIV_STEPS  = UNIT_FRAC + 1;
   localparam int DIV_REM_W  = ROOT_W + 1;
   localparam int LANES      = 3;
   localparam int FRONT_REGS = 3;
   localparam int LATENCY    = FRONT_REGS + ROOT_W + DIV_STEPS + 1;
endpackage

[src/vn_div_lane.sv]
// one lane of the pipelined restoring divider, one quotient bit per stage
`timescale 1ns / 1ps
module vn_div_lane (
   input  logic                           clock,
   input  logic                           enable,
   input  logic [vn_pkg::CW-1:0]          mag,
   input  logic [vn_pkg::ROOT_W-1:0]      divisor,
   output logic [vn_pkg::DIV_STEPS-1:0]   quotient
);
   logic [vn_pkg::DIV_REM_W-1:0] rem_ff [0:vn_pkg::DIV_STEPS];
   logic [vn_pkg::ROOT_W-1:0]    div_ff [0:vn_pkg::DIV_STEPS];
   logic [vn_pkg::DIV_STEPS-1:0] q_ff   [0:vn_pkg::DIV_STEPS];

   assign rem_ff[0] = {1'b0, mag};
   assign div_ff[0] = divisor;
   assign q_ff[0]   = '0;

   for (genvar j = 0; j < vn_pkg::DIV_STEPS; j++) begin : g_step
      logic [vn_pkg::DIV_REM_W-1:0] cur_in;
      logic [vn_pkg::DIV_REM_W-1:0] rem_in;
      logic                         ge_in;
      always_comb begin
         if (j == 0) begin
            cur_in = rem_ff[j];
         end else begin
            cur_in = {rem_ff[j][vn_pkg::DIV_REM_W-2:0], 1'b0};
         end
         ge_in  = cur_in >= {1'b0, div_ff[j]};
         rem_in = ge_in ? (cur_in - {1'b0, div_ff[j]}) : cur_in;
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            rem_ff[j+1] <= rem_in;
            div_ff[j+1] <= div_ff[j];
            q_ff[j+1]   <= {q_ff[j][vn_pkg::DIV_STEPS-2:0], ge_in};
         end
      end
   end

   assign quotient = q_ff[vn_pkg::DIV_STEPS];
endmodule

[src/vector3_normalize.sv]
// vector3_normalize: front, square-root and divider stages, then the output register
// throughput one item per cycle; the whole pipeline holds while the result is stalled
// the depth comes from one square-root bit per stage and one quotient bit per stage
// reset clears the valid bits of every stage; data registers are not reset
`timescale 1ns / 1ps
module vector3_normalize (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [vn_pkg::CW-1:0]  req_in_x,
   input  logic signed [vn_pkg::CW-1:0]  req_in_y,
   input  logic signed [vn_pkg::CW-1:0]  req_in_z,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [vn_pkg::UNIT_W-1:0] rsp_unit_x,
   output logic signed [vn_pkg::UNIT_W-1:0] rsp_unit_y,
   output logic signed [vn_pkg::UNIT_W-1:0] rsp_unit_z,
   output logic [vn_pkg::MAG_W-1:0]      rsp_magnitude,
   output logic                          rsp_zero_vector
);
   localparam int NS = vn_pkg::ROOT_W;

   logic enable;
   logic [vn_pkg::CW-1:0]     in_raw [0:vn_pkg::LANES-1];

   // front stages
   logic                      v0_ff, v1_ff, v2_ff;
   logic [vn_pkg::CW-1:0]     mag0_ff [0:vn_pkg::LANES-1];
   logic [vn_pkg::CW-1:0]     mag1_ff [0:vn_pkg::LANES-1];
   logic [vn_pkg::LANES-1:0]  neg0_ff, neg1_ff;
   logic [vn_pkg::SUM_W-1:0]  sq1_ff  [0:vn_pkg::LANES-1];

   // square root stages
   logic                      sv_ff   [0:NS];
   logic [vn_pkg::SUM_W-1:0]  s_ff    [0:NS];
   logic [vn_pkg::SQ_REM_W-1:0] srem_ff [0:NS];
   logic [vn_pkg::ROOT_W-1:0] root_ff [0:NS];
   logic [vn_pkg::CW-1:0]     smag_ff [0:NS][0:vn_pkg::LANES-1];
   logic [vn_pkg::LANES-1:0]  sneg_ff [0:NS];
   logic                      szero_ff [0:NS];

   // divider sideband
   logic                      dv_ff   [0:vn_pkg::DIV_STEPS];
   logic [vn_pkg::LANES-1:0]  dneg_ff [0:vn_pkg::DIV_STEPS];
   logic                      dzero_ff [0:vn_pkg::DIV_STEPS];
   logic [vn_pkg::ROOT_W-1:0] droot_ff [0:vn_pkg::DIV_STEPS];
   logic [vn_pkg::DIV_STEPS-1:0] quot [0:vn_pkg::LANES-1];

   logic                      out_valid_ff;
   logic [vn_pkg::UNIT_W-1:0] unit_ff [0:vn_pkg::LANES-1];
   logic [vn_pkg::MAG_W-1:0]  mag_out_ff;
   logic                      zero_out_ff;

   assign enable    = !(out_valid_ff && rsp_stall);
   assign req_stall = !enable;
   assign in_raw[0] = req_in_x;
   assign in_raw[1] = req_in_y;
   assign in_raw[2] = req_in_z;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (enable) begin
         v0_ff <= req_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
   end

   // absolute value, then squares, then sum
   for (genvar k = 0; k < vn_pkg::LANES; k++) begin : g_front
      always_ff @(posedge clock) begin
         if (enable) begin
            neg0_ff[k] <= in_raw[k][vn_pkg::CW-1];
            mag0_ff[k] <= in_raw[k][vn_pkg::CW-1] ? (~in_raw[k] + 1'b1) : in_raw[k];
            neg1_ff[k] <= neg0_ff[k];
            mag1_ff[k] <= mag0_ff[k];
            sq1_ff[k]  <= {{vn_pkg::CW{1'b0}}, mag0_ff[k]} * {{vn_pkg::CW{1'b0}}, mag0_ff[k]};
            smag_ff[0][k] <= mag1_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         s_ff[0]     <= sq1_ff[0] + sq1_ff[1] + sq1_ff[2];
         sneg_ff[0]  <= neg1_ff;
         szero_ff[0] <= (mag1_ff[0] == '0) && (mag1_ff[1] == '0) && (mag1_ff[2] == '0);
      end
   end

   assign sv_ff[0]   = v2_ff;
   assign srem_ff[0] = '0;
   assign root_ff[0] = '0;

   // one root bit per stage
   for (genvar k = 0; k < NS; k++) begin : g_sqrt
      logic [vn_pkg::SQ_REM_W-1:0] cur_in;
      logic [vn_pkg::SQ_REM_W-1:0] trial_in;
      logic                        ge_in;
      always_comb begin
         cur_in   = {srem_ff[k][vn_pkg::SQ_REM_W-3:0], s_ff[k][vn_pkg::SUM_W-1 -: 2]};
         trial_in = {1'b0, root_ff[k], 2'b01};
         ge_in    = cur_in >= trial_in;
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[k+1] <= 1'b0;
         end else if (enable) begin
            sv_ff[k+1] <= sv_ff[k];
         end
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            s_ff[k+1]     <= {s_ff[k][vn_pkg::SUM_W-3:0], 2'b00};
            srem_ff[k+1]  <= ge_in ? (cur_in - trial_in) : cur_in;
            root_ff[k+1]  <= {root_ff[k][vn_pkg::ROOT_W-2:0], ge_in};
            smag_ff[k+1]  <= smag_ff[k];
            sneg_ff[k+1]  <= sneg_ff[k];
            szero_ff[k+1] <= szero_ff[k];
         end
      end
   end

   for (genvar k = 0; k < vn_pkg::LANES; k++) begin : g_lane
      vn_div_lane u_div (
         .clock    (clock),
         .enable   (enable),
         .mag      (smag_ff[NS][k]),
         .divisor  (root_ff[NS]),
         .quotient (quot[k])
      );
   end

   assign dv_ff[0]    = sv_ff[NS];
   assign dneg_ff[0]  = sneg_ff[NS];
   assign dzero_ff[0] = szero_ff[NS];
   assign droot_ff[0] = root_ff[NS];

   for (genvar j = 0; j < vn_pkg::DIV_STEPS; j++) begin : g_side
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[j+1] <= 1'b0;
         end else if (enable) begin
            dv_ff[j+1] <= dv_ff[j];
         end
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            dneg_ff[j+1]  <= dneg_ff[j];
            dzero_ff[j+1] <= dzero_ff[j];
            droot_ff[j+1] <= droot_ff[j];
         end
      end
   end

   // output register, sign applied and zero vector forced
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (enable) begin
         out_valid_ff <= dv_ff[vn_pkg::DIV_STEPS];
      end
   end

   for (genvar k = 0; k < vn_pkg::LANES; k++) begin : g_out
      logic [vn_pkg::UNIT_W-1:0] q_in;
      always_comb begin
         q_in = {{(vn_pkg::UNIT_W - vn_pkg::DIV_STEPS){1'b0}}, quot[k]};
      end
      always_ff @(posedge clock) begin
         if (enable) begin
            if (dzero_ff[vn_pkg::DIV_STEPS]) begin
               unit_ff[k] <= '0;
            end else if (dneg_ff[vn_pkg::DIV_STEPS][k]) begin
               unit_ff[k] <= ~q_in + 1'b1;
            end else begin
               unit_ff[k] <= q_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         zero_out_ff <= dzero_ff[vn_pkg::DIV_STEPS];
         mag_out_ff  <= dzero_ff[vn_pkg::DIV_STEPS] ? '0
                        : {1'b0, droot_ff[vn_pkg::DIV_STEPS]};
      end
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_unit_x      = unit_ff[0];
   assign rsp_unit_y      = unit_ff[1];
   assign rsp_unit_z      = unit_ff[2];
   assign rsp_magnitude   = mag_out_ff;
   assign rsp_zero_vector = zero_out_ff;
endmodule
